### sv/fbpa_pkg.sv
package fbpa_pkg;

    // slot index and pool geometry
    localparam int SLOT_W      = 7;
    localparam int SLOT_COUNT  = 128;
    localparam int BLK_W       = 5;
    localparam int CARVE_LIMIT = 31;
    localparam int STATUS_W    = 2;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_FREE  = 2'd2;

    // request operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [SLOT_W-1:0] slot_to_free;
    } in_item_t;

    typedef struct packed {
        logic [SLOT_W-1:0]   granted_slot;
        logic [STATUS_W-1:0] status;
    } out_item_t;

endpackage

### sv/fixed_block_pool_allocator_top.sv
// allocate from the free list or free: pop or free state, then response state
// exhausted allocate: response state; allocate that carves a block: carve, wait, pop, response
// the response state waits for a free output register; only then is the next item taken in idle
// the next item is accepted while an earlier result still waits in the output register
// reset clears control, list head and block count at once
// the memory is not cleared: carving a block writes each link and clears each busy mark
module fixed_block_pool_allocator_top #(
    parameter int ELEMENTS_PER_BLOCK = 8,
    parameter int NUM_BLOCKS         = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  fbpa_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output fbpa_pkg::out_item_t out_data
);

    localparam int SLOT_W  = fbpa_pkg::SLOT_W;
    localparam int BLK_W   = fbpa_pkg::BLK_W;
    localparam int ENTRY_W = SLOT_W + 1;
    localparam int EPB     = ELEMENTS_PER_BLOCK;
    localparam int CNT_W   = (EPB > 1) ? $clog2(EPB) : 1;
    localparam int PROD_W  = fbpa_pkg::BLK_W + $clog2(EPB + 1);
    localparam int BASE_W  = (PROD_W > SLOT_W + 1) ? PROD_W : SLOT_W + 1;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_POP   = 3'd1;
    localparam logic [2:0] S_FREE  = 3'd2;
    localparam logic [2:0] S_CARVE = 3'd3;
    localparam logic [2:0] S_WAIT  = 3'd4;
    localparam logic [2:0] S_RESP  = 3'd5;

    logic [2:0]                      state_reg, state_next;
    logic [SLOT_W-1:0]               free_head_reg, free_head_next;
    logic                            empty_reg, empty_next;
    logic [fbpa_pkg::BLK_W-1:0]      blocks_reg, blocks_next;
    logic [CNT_W-1:0]                cnt_reg, cnt_next;
    logic [SLOT_W-1:0]               base_reg, base_next;
    logic [SLOT_W-1:0]               slot_reg, slot_next;
    fbpa_pkg::out_item_t             res_reg, res_next;
    logic                            out_valid_reg, out_valid_next;
    fbpa_pkg::out_item_t             out_data_reg, out_data_next;

    // slot memory, each entry holds the busy mark over the list link
    // one write and one registered read per cycle
    logic [ENTRY_W-1:0] link_mem [fbpa_pkg::SLOT_COUNT];
    logic [ENTRY_W-1:0] link_rd_reg;
    logic [SLOT_W-1:0]  link_ra;
    logic               link_we;
    logic [SLOT_W-1:0]  link_wa;
    logic [ENTRY_W-1:0] link_wd;

    logic [BASE_W-1:0] base_wide;
    logic [BASE_W-1:0] end_wide;
    logic              can_carve;
    logic [SLOT_W-1:0] carve_addr;
    logic              carve_last;
    logic              out_free;
    logic              slot_busy;

    // read the slot named by a free item as it is accepted, otherwise the list head
    assign link_ra = (state_reg == S_IDLE && in_valid
                      && in_data.operation == fbpa_pkg::OP_FREE)
                   ? in_data.slot_to_free : free_head_reg;

    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_wa] <= link_wd;
        end
        link_rd_reg <= link_mem[link_ra];
    end

    // next block geometry
    assign base_wide = BASE_W'(blocks_reg) * BASE_W'(EPB);
    assign end_wide  = base_wide + BASE_W'(EPB);
    assign can_carve = (32'(blocks_reg) < 32'(NUM_BLOCKS))
                    && (32'(blocks_reg) < 32'(fbpa_pkg::CARVE_LIMIT))
                    && (end_wide <= BASE_W'(fbpa_pkg::SLOT_COUNT));

    assign carve_addr = base_reg + SLOT_W'(cnt_reg);
    assign carve_last = (32'(cnt_reg) == 32'(EPB - 1));
    assign out_free   = !out_valid_reg || out_ready;

    // slots beyond the carved blocks are never busy
    assign slot_busy  = (BASE_W'(slot_reg) < base_wide) && link_rd_reg[SLOT_W];

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        free_head_next = free_head_reg;
        empty_next     = empty_reg;
        blocks_next    = blocks_reg;
        cnt_next       = cnt_reg;
        base_next      = base_reg;
        slot_next      = slot_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        link_we        = 1'b0;
        link_wa        = carve_addr;
        link_wd        = {1'b0, carve_addr};

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    slot_next = in_data.slot_to_free;
                    if (in_data.operation == fbpa_pkg::OP_FREE)
                    begin
                        state_next = S_FREE;
                    end
                    else if (!empty_reg)
                    begin
                        state_next = S_POP;
                    end
                    else if (can_carve)
                    begin
                        base_next  = base_wide[SLOT_W-1:0];
                        cnt_next   = '0;
                        state_next = S_CARVE;
                    end
                    else
                    begin
                        res_next.granted_slot = '0;
                        res_next.status       = fbpa_pkg::ST_EXHAUSTED;
                        state_next            = S_RESP;
                    end
                end
            end
            S_POP:
            begin
                res_next.granted_slot = free_head_reg;
                res_next.status       = fbpa_pkg::ST_OK;
                // mark the head busy, keeping its link
                link_we = 1'b1;
                link_wa = free_head_reg;
                link_wd = {1'b1, link_rd_reg[SLOT_W-1:0]};
                if (link_rd_reg[SLOT_W-1:0] == free_head_reg)
                begin
                    empty_next = 1'b1;
                end
                else
                begin
                    free_head_next = link_rd_reg[SLOT_W-1:0];
                end
                state_next = S_RESP;
            end
            S_FREE:
            begin
                res_next.granted_slot = '0;
                if (!slot_busy)
                begin
                    res_next.status = fbpa_pkg::ST_BAD_FREE;
                end
                else
                begin
                    res_next.status = fbpa_pkg::ST_OK;
                    link_we         = 1'b1;
                    link_wa         = slot_reg;
                    link_wd         = {1'b0, empty_reg ? slot_reg : free_head_reg};
                    free_head_next  = slot_reg;
                    empty_next      = 1'b0;
                end
                state_next = S_RESP;
            end
            S_CARVE:
            begin
                link_we = 1'b1;
                link_wa = carve_addr;
                if (carve_last)
                begin
                    link_wd        = {1'b0, carve_addr};
                    free_head_next = base_reg;
                    empty_next     = 1'b0;
                    blocks_next    = blocks_reg + BLK_W'(1);
                    state_next     = S_WAIT;
                end
                else
                begin
                    link_wd  = {1'b0, carve_addr + SLOT_W'(1)};
                    cnt_next = cnt_reg + CNT_W'(1);
                end
            end
            S_WAIT:
            begin
                // link read of the new head is made here, ready for the pop
                state_next = S_POP;
            end
            S_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            free_head_reg <= '0;
            empty_reg     <= 1'b1;
            blocks_reg    <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            empty_reg     <= empty_next;
            blocks_reg    <= blocks_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        base_reg     <= base_next;
        slot_reg     <= slot_next;
        res_reg      <= res_next;
        out_data_reg <= out_data_next;
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // a failed or free result never names a slot
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.status != fbpa_pkg::ST_OK) |->
            (out_data_reg.granted_slot == '0))
        else $error("non-ok result carries a slot");

    // pop only after idle or after the carve settle cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |->
            ($past(state_reg) == S_IDLE) || ($past(state_reg) == S_WAIT))
        else $error("pop without a valid link read");

    // a granted slot is marked busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP) |->
            (link_we && (link_wa == free_head_reg) && link_wd[SLOT_W]))
        else $error("granted slot not marked busy");

    // carving stays inside the pool
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CARVE) |->
            ((BASE_W'(base_reg) + BASE_W'(cnt_reg)) < BASE_W'(fbpa_pkg::SLOT_COUNT)))
        else $error("carve beyond last slot");

    // block count never above NUM_BLOCKS
    assert property (@(posedge clk) disable iff (!rst_n)
        (32'(blocks_reg) <= 32'(NUM_BLOCKS)))
        else $error("too many blocks carved");

endmodule

### sim/pool_grant_checker.sv
`timescale 1ns / 1ps

module pool_grant_checker #(
    parameter int ELEMENTS_PER_BLOCK = 8,
    parameter int NUM_BLOCKS         = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  fbpa_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  fbpa_pkg::out_item_t out_data,
    output int                  fail_count,
    output int                  outstanding
);

    localparam int SLOT_W     = fbpa_pkg::SLOT_W;
    localparam int SLOT_COUNT = fbpa_pkg::SLOT_COUNT;
    localparam int BLK_W      = fbpa_pkg::BLK_W;

    // shadow copy of the pool state
    logic [SLOT_W-1:0] link_mem [SLOT_COUNT];
    logic              slot_busy [SLOT_COUNT];
    logic [SLOT_W-1:0] list_head;
    logic              list_empty;
    logic [BLK_W-1:0]  carved_blocks;

    // results still owed by the block, oldest first
    fbpa_pkg::out_item_t expected_grants [$];

    initial fail_count = 0;
    initial outstanding = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t ns: %s", $time, what);
        fail_count++;
    endtask

    // carve the next block onto the empty list, if one may still be carved
    function automatic void carve_next_block();
        int first;
        int k;
        first = int'(carved_blocks) * ELEMENTS_PER_BLOCK;
        if (ELEMENTS_PER_BLOCK < 1 || ELEMENTS_PER_BLOCK > SLOT_COUNT)
            return;
        if (int'(carved_blocks) >= NUM_BLOCKS
            || int'(carved_blocks) >= fbpa_pkg::CARVE_LIMIT)
            return;
        if (first + ELEMENTS_PER_BLOCK > SLOT_COUNT)
            return;
        for (k = 0; k < ELEMENTS_PER_BLOCK; k++)
        begin
            // ascending links, last slot of the block points at itself
            if (k == ELEMENTS_PER_BLOCK - 1)
                link_mem[first + k] = SLOT_W'(first + k);
            else
                link_mem[first + k] = SLOT_W'(first + k + 1);
        end
        list_head     = SLOT_W'(first);
        list_empty    = 1'b0;
        carved_blocks = carved_blocks + BLK_W'(1);
    endfunction

    // apply one request to the shadow pool and return the result it owes
    function automatic fbpa_pkg::out_item_t apply_request(input fbpa_pkg::in_item_t req);
        fbpa_pkg::out_item_t res;
        logic [SLOT_W-1:0]   slot;
        res.granted_slot = '0;
        res.status       = fbpa_pkg::ST_OK;
        slot             = req.slot_to_free;
        if (req.operation == fbpa_pkg::OP_ALLOC)
        begin
            if (list_empty)
                carve_next_block();
            if (list_empty)
                res.status = fbpa_pkg::ST_EXHAUSTED;
            else
            begin
                res.granted_slot            = list_head;
                slot_busy[list_head]        = 1'b1;
                // a self link marks the tail of the free list
                if (link_mem[list_head] == list_head)
                    list_empty = 1'b1;
                else
                    list_head = link_mem[list_head];
            end
        end
        else
        begin
            if (!slot_busy[slot])
                res.status = fbpa_pkg::ST_BAD_FREE;
            else
            begin
                link_mem[slot]  = list_empty ? slot : list_head;
                list_head       = slot;
                list_empty      = 1'b0;
                slot_busy[slot] = 1'b0;
            end
        end
        return res;
    endfunction

    // compare delivered results, then predict for accepted items
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SLOT_COUNT; k++)
            begin
                link_mem[k]  = '0;
                slot_busy[k] = 1'b0;
            end
            list_head     = '0;
            list_empty    = 1'b1;
            carved_blocks = '0;
            expected_grants.delete();
            outstanding   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_grants.size() == 0)
                    report_mismatch($sformatf("unexpected result slot %0d status %0d",
                                              out_data.granted_slot, out_data.status));
                else
                begin
                    fbpa_pkg::out_item_t want;
                    want = expected_grants.pop_front();
                    if (out_data.granted_slot !== want.granted_slot)
                        report_mismatch($sformatf("granted_slot %0d, expected %0d",
                                                  out_data.granted_slot, want.granted_slot));
                    if (out_data.status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  out_data.status, want.status));
                end
            end
            if (in_valid && in_ready)
                expected_grants.push_back(apply_request(in_data));
            outstanding = expected_grants.size();
        end
    end

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int SLOT_W             = fbpa_pkg::SLOT_W;
    localparam int ELEMENTS_PER_BLOCK = 8;
    localparam int NUM_BLOCKS         = 16;
    localparam int PHASES             = 8;
    localparam int ITEMS_PER_PHASE    = 130;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                in_valid  = 1'b0;
    fbpa_pkg::in_item_t  in_data   = '0;
    logic                out_ready = 1'b0;
    logic                in_ready;
    logic                out_valid;
    fbpa_pkg::out_item_t out_data;
    int                  fail_count;
    int                  outstanding;

    // idling controls for the sender and receiver
    int gap_pct     = 0;
    int stall_pct   = 0;
    int hold_cycles = 0;

    // operations in flight, and slots granted and not yet freed by the stimulus
    logic              op_q [$];
    logic [SLOT_W-1:0] held_slots [$];
    logic              done_op;

    fixed_block_pool_allocator_top #(
        .ELEMENTS_PER_BLOCK (ELEMENTS_PER_BLOCK),
        .NUM_BLOCKS         (NUM_BLOCKS)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    pool_grant_checker #(
        .ELEMENTS_PER_BLOCK (ELEMENTS_PER_BLOCK),
        .NUM_BLOCKS         (NUM_BLOCKS)
    ) u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // give up after a generous fixed time
    initial
    begin
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver: random stalls, or a long hold-off when asked
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_cycles--;
            end
            else
                out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // learn granted slots so that most frees return a slot really in use
    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            op_q.push_back(in_data.operation);
        if (out_valid && out_ready && op_q.size() > 0)
        begin
            done_op = op_q.pop_front();
            if (done_op == fbpa_pkg::OP_ALLOC && out_data.status == fbpa_pkg::ST_OK)
                held_slots.push_back(out_data.granted_slot);
        end
    end

    // offer one item and wait until it is taken
    task automatic send_request(input logic op, input logic [SLOT_W-1:0] slot);
        while ($urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid               <= 1'b1;
        in_data.operation      <= op;
        in_data.slot_to_free   <= slot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // random request: an allocate at the given chance, else mostly frees of held slots, some frees of any slot
    task automatic send_random_request(input int alloc_pct);
        logic [SLOT_W-1:0] slot;
        int                idx;
        slot = SLOT_W'($urandom);
        if ($urandom_range(0, 99) < alloc_pct)
            send_request(fbpa_pkg::OP_ALLOC, slot);
        else
        begin
            if (held_slots.size() > 0 && $urandom_range(0, 9) != 0)
            begin
                idx  = $urandom_range(0, held_slots.size() - 1);
                slot = held_slots[idx];
                held_slots.delete(idx);
            end
            send_request(fbpa_pkg::OP_FREE, slot);
        end
    endtask

    // stimulus and verdict
    initial
    begin
        int gap_tab   [4];
        int stall_tab [4];
        int alloc_tab [PHASES];

        gap_tab   = '{0, 59, 0, 30};
        stall_tab = '{0, 0, 59, 30};
        alloc_tab = '{80, 80, 30, 50, 85, 20, 70, 40};

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // frees of slots never carved, at both ends of the range
        send_request(fbpa_pkg::OP_FREE, 7'd0);
        send_request(fbpa_pkg::OP_FREE, 7'd127);
        // first allocate carves block 0; the slot field is ignored
        send_request(fbpa_pkg::OP_ALLOC, 7'd127);
        repeat (7) send_request(fbpa_pkg::OP_ALLOC, 7'd0);
        // free onto an empty list links to itself; a second free is refused
        send_request(fbpa_pkg::OP_FREE, 7'd5);
        send_request(fbpa_pkg::OP_FREE, 7'd5);
        send_request(fbpa_pkg::OP_ALLOC, 7'd85);
        // list empty again, so this one carves block 1
        send_request(fbpa_pkg::OP_ALLOC, 7'd42);
        send_request(fbpa_pkg::OP_FREE, 7'd0);
        send_request(fbpa_pkg::OP_FREE, 7'd1);
        send_request(fbpa_pkg::OP_ALLOC, 7'd0);
        send_request(fbpa_pkg::OP_ALLOC, 7'd0);
        send_request(fbpa_pkg::OP_ALLOC, 7'd0);
        send_request(fbpa_pkg::OP_FREE, 7'd127);
        send_request(fbpa_pkg::OP_FREE, 7'd16);

        // random phases; the early alloc-heavy phases run the pool dry
        for (int p = 0; p < PHASES; p++)
        begin
            gap_pct   = gap_tab[p % 4];
            stall_pct = stall_tab[p % 4];
            if (p == 0)
                hold_cycles = 300;
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
                send_random_request(alloc_tab[p]);
        end
        in_valid <= 1'b0;

        // drain and let the block settle
        while (outstanding != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

### sim.f
sv/fbpa_pkg.sv
sv/fixed_block_pool_allocator_top.sv
sim/pool_grant_checker.sv
sim/tb_top.sv
